/* hw/rtl/point_pair_heading_elevation_distance_top_defines.svh */
// Assertion macros for the point pair heading, elevation and distance block.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef POINT_PAIR_HEADING_ELEVATION_DISTANCE_TOP_DEFINES_SVH
`define POINT_PAIR_HEADING_ELEVATION_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define PPHED_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define PPHED_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pphed_pkg.sv */
// Shared types, constants and the angle rounding function.
// No dependencies; used by the CORDIC unit, the back end and the top module.
`default_nettype none

package pphed_pkg;

  // angle accumulator width, Q.24 radians
  localparam int ZW       = 28;
  localparam int RQW      = ZW - 10;
  localparam int ATAN_LEN = 24;
  localparam int NORM_MSB = 30;
  localparam int SW       = 5;
  localparam int RED_W    = 25;
  localparam int RED_MSB  = 24;
  localparam int ELEV_SQ_SHIFT = 14;
  localparam int ELEV_Y_SHIFT  = 7;

  localparam logic signed [ZW-1:0] ATAN_Q24 [ATAN_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353590;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic [24:0]          DIST_MAX    = 25'h1FFFFFF;
  localparam logic [63:0]          DIST_LIM    = 64'd33554432;

  typedef struct packed {
    logic dz_zero;
    logic dx_pos;
    logic all_zero;
  } flags_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [14:0] elevation;
    logic [24:0]        distance;
  } res_t;

  // Round half up from Q.24 to Q3.13, then clamp to +-lim.
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [ZW:0]    t;
    logic signed [RQW-1:0] r;
    t = $signed({z[ZW-1], z}) + $signed((ZW+1)'(1024));
    r = t[ZW:11];
    if (r > RQW'(lim)) begin
      r = RQW'(lim);
    end else if (r < -RQW'(lim)) begin
      r = -RQW'(lim);
    end
    return 16'(r);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pphed_fifo.sv */
// First-word fall-through queue in flip-flops, used on both sides of the back end.
// Needs the assertion macro header.
`default_nettype none
`include "point_pair_heading_elevation_distance_top_defines.svh"

module pphed_fifo #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `PPHED_ASSERT(a_full_not_empty, clk_i, rst_ni, full_o, !empty_o, "queue full and empty")
  `PPHED_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, do_push, !empty_o, "beat lost on push")
  `PPHED_ASSERT_NEXT(a_last_pop, clk_i, rst_ni, do_pop && !push_i && (cnt_q == CW'(1)), empty_o, "queue not drained")

endmodule

`default_nettype wire

/* hw/rtl/pphed_isqrt.sv */
// Pipelined integer square root, one root bit per stage, floor root and remainder.
// Uses no package items.
`default_nettype none

module pphed_isqrt #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] n_i,
  output logic [W-1:0]   root_o,
  output logic [W+1:0]   rem_o
);
  localparam int RW = W + 2;

  logic [RW-1:0]  rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] nr_q   [W];
  logic [RW-1:0]  rem_d  [W];
  logic [W-1:0]   root_d [W];
  logic [2*W-1:0] nr_d   [W];

  always_comb begin
    logic [RW-1:0]  pr;
    logic [W-1:0]   pq;
    logic [2*W-1:0] pn;
    logic [RW+1:0]  t, trial;
    for (int j = 0; j < W; j++) begin
      pr = (j == 0) ? '0 : rem_q[(j == 0) ? 0 : j - 1];
      pq = (j == 0) ? '0 : root_q[(j == 0) ? 0 : j - 1];
      pn = (j == 0) ? n_i : nr_q[(j == 0) ? 0 : j - 1];
      t     = {pr, pn[2*W-1:2*W-2]};
      trial = {2'b00, pq, 2'b01};
      if (t >= trial) begin
        rem_d[j]  = RW'(t - trial);
        root_d[j] = {pq[W-2:0], 1'b1};
      end else begin
        rem_d[j]  = RW'(t);
        root_d[j] = {pq[W-2:0], 1'b0};
      end
      nr_d[j] = pn << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < W; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        nr_q[j]   <= nr_d[j];
      end
    end
  end

  assign root_o = root_q[W-1];
  assign rem_o  = rem_q[W-1];

endmodule

`default_nettype wire

/* hw/rtl/pphed_cordic.sv */
// Pipelined CORDIC vectoring unit: normalise, fold into the right half plane, iterate.
// Depends on pphed_pkg for the arctangent table and angle width.
`default_nettype none

module pphed_cordic #(
  parameter int CW    = 35,
  parameter int STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [CW-1:0]           x_i,
  input  logic signed [CW-1:0]           y_i,
  output logic signed [pphed_pkg::ZW-1:0] z_o
);
  import pphed_pkg::*;

  localparam int MW = $clog2(CW);

  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [CW-1:0]        m0_d, m0_q;
  logic [SW-1:0]        s1_d, s1_q;
  logic signed [CW-1:0] xs_q [STEPS+1];
  logic signed [CW-1:0] ys_q [STEPS+1];
  logic signed [ZW-1:0] zs_q [STEPS+1];
  logic signed [CW-1:0] xs_d [STEPS];
  logic signed [CW-1:0] ys_d [STEPS];
  logic signed [ZW-1:0] zs_d [STEPS];
  logic signed [CW-1:0] xr_d, yr_d;
  logic signed [ZW-1:0] zr_d;

  // larger magnitude of the two inputs
  always_comb begin
    logic [CW-1:0] ax, ay;
    ax   = x_i[CW-1] ? CW'(-x_i) : CW'(x_i);
    ay   = y_i[CW-1] ? CW'(-y_i) : CW'(y_i);
    m0_d = (ax > ay) ? ax : ay;
  end

  // shift that lifts the leading one to NORM_MSB
  always_comb begin
    logic [MW-1:0] msb;
    msb = '0;
    for (int b = 0; b < CW; b++) begin
      if (m0_q[b]) begin
        msb = MW'(b);
      end
    end
    s1_d = (int'(msb) >= NORM_MSB) ? '0 : SW'(NORM_MSB - int'(msb));
  end

  // left half plane folded by a quarter turn
  always_comb begin
    xr_d = x2_q;
    yr_d = y2_q;
    zr_d = '0;
    if (x2_q < 0) begin
      if (y2_q >= 0) begin
        xr_d = y2_q;
        yr_d = -x2_q;
        zr_d = HALF_PI_Q24;
      end else begin
        xr_d = -y2_q;
        yr_d = x2_q;
        zr_d = -HALF_PI_Q24;
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] xsh, ysh;
    for (int i = 0; i < STEPS; i++) begin
      xsh = xs_q[i] >>> i;
      ysh = ys_q[i] >>> i;
      if (ys_q[i] > 0) begin
        xs_d[i] = xs_q[i] + ysh;
        ys_d[i] = ys_q[i] - xsh;
        zs_d[i] = zs_q[i] + ATAN_Q24[i];
      end else begin
        xs_d[i] = xs_q[i] - ysh;
        ys_d[i] = ys_q[i] + xsh;
        zs_d[i] = zs_q[i] - ATAN_Q24[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= x_i;
      y0_q    <= y_i;
      m0_q    <= m0_d;
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      s1_q    <= s1_d;
      x2_q    <= x1_q <<< s1_q;
      y2_q    <= y1_q <<< s1_q;
      xs_q[0] <= xr_d;
      ys_q[0] <= yr_d;
      zs_q[0] <= zr_d;
      for (int i = 0; i < STEPS; i++) begin
        xs_q[i+1] <= xs_d[i];
        ys_q[i+1] <= ys_d[i];
        zs_q[i+1] <= zs_d[i];
      end
    end
  end

  assign z_o = zs_q[STEPS];

endmodule

`default_nettype wire

/* hw/rtl/pphed_back.sv */
// Back end: range reduction, squares, two square roots, two CORDIC units, output rounding.
// Depends on pphed_pkg, pphed_isqrt and pphed_cordic; one global advance enable.
`default_nettype none

module pphed_back #(
  parameter int COORD_BITS   = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_vld_i,
  input  logic signed [COORD_BITS:0] dx_i,
  input  logic signed [COORD_BITS:0] dy_i,
  input  logic signed [COORD_BITS:0] dz_i,
  input  pphed_pkg::flags_t       flags_i,
  output logic                    out_vld_o,
  output pphed_pkg::res_t         res_o
);
  import pphed_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int CW  = ((COORD_BITS > 32) ? COORD_BITS : 32) + 3;
  localparam int SQW = 32;
  localparam int CL  = CORDIC_STEPS + 4;
  localparam int LAT = SQW + CL + 6;
  localparam int KW  = $clog2(COORD_BITS);
  localparam int PW  = 2 * RED_W;

  typedef struct packed {
    flags_t                   f;
    logic                     sat;
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dz;
    logic signed [RED_W-1:0]  ry;
  } sb1_t;

  typedef struct packed {
    flags_t       f;
    logic         sat;
    logic [SQW:0] dr;
  } sb2_t;

  logic [LAT-1:0] vld_q;

  // stage 1: magnitudes
  logic signed [DW-1:0]  dx1_q, dy1_q, dz1_q;
  logic [COORD_BITS-1:0] ax1_q, ay1_q, az1_q, m1_q;
  logic [COORD_BITS-1:0] ax_d, ay_d, az_d, m_d;
  flags_t                f1_q;
  // stage 2: reduction shift
  logic signed [DW-1:0]  dx2_q, dy2_q, dz2_q;
  logic [RED_W-1:0]      ax2_q, ay2_q, az2_q;
  logic [KW-1:0]         k_d, k2_q;
  logic                  sat2_q;
  flags_t                f2_q;
  // stage 3: reduced deltas
  logic signed [RED_W-1:0] rx3_q, rz3_q;
  logic [RED_W-1:0]        ax3_q, ay3_q, az3_q;
  sb1_t                    sb3_q;
  // stage 4: squares
  logic signed [PW-1:0]  sqx4_q, sqz4_q;
  logic [PW-1:0]         pdx4_q, pdy4_q, pdz4_q;
  // stage 5: root operands
  logic [2*SQW-1:0]      ne5_q, nd5_q;

  sb1_t                  sbd_q [SQW+2];
  sb2_t                  sb2_q [CL];
  sb1_t                  sbs;
  sb2_t                  sbc;

  logic [SQW-1:0]        root_e, root_d;
  logic [SQW+1:0]        rem_d;
  logic [SQW:0]          dr_d;
  logic signed [CW-1:0]  hx, hy, ex, ey;
  logic signed [ZW-1:0]  zh, ze;
  res_t                  res_d, res_q;

  always_comb begin
    ax_d = dx_i[DW-1] ? COORD_BITS'(-dx_i) : COORD_BITS'(dx_i);
    ay_d = dy_i[DW-1] ? COORD_BITS'(-dy_i) : COORD_BITS'(dy_i);
    az_d = dz_i[DW-1] ? COORD_BITS'(-dz_i) : COORD_BITS'(dz_i);
    m_d  = (ax_d > ay_d) ? ax_d : ay_d;
    m_d  = (az_d > m_d) ? az_d : m_d;
  end

  always_comb begin
    k_d = '0;
    for (int b = RED_MSB; b < COORD_BITS; b++) begin
      if (m1_q[b]) begin
        k_d = KW'(b - RED_MSB + 1);
      end
    end
  end

  assign sbs = sbd_q[SQW+1];
  assign sbc = sb2_q[CL-1];

  // round the distance root to nearest
  assign dr_d = (SQW+1)'(root_d) + (SQW+1)'(rem_d > (SQW+2)'(root_d));

  assign hx = CW'(sbs.dz);
  assign hy = CW'(sbs.dx);
  assign ex = $signed(CW'(root_e));
  assign ey = CW'(sbs.ry) <<< ELEV_Y_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q  <= dx_i;
      dy1_q  <= dy_i;
      dz1_q  <= dz_i;
      ax1_q  <= ax_d;
      ay1_q  <= ay_d;
      az1_q  <= az_d;
      m1_q   <= m_d;
      f1_q   <= flags_i;

      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      dz2_q  <= dz1_q;
      ax2_q  <= RED_W'(ax1_q);
      ay2_q  <= RED_W'(ay1_q);
      az2_q  <= RED_W'(az1_q);
      k2_q   <= k_d;
      sat2_q <= (64'(ax1_q) >= DIST_LIM) || (64'(ay1_q) >= DIST_LIM)
                || (64'(az1_q) >= DIST_LIM);
      f2_q   <= f1_q;

      rx3_q     <= RED_W'(dx2_q >>> k2_q);
      rz3_q     <= RED_W'(dz2_q >>> k2_q);
      ax3_q     <= ax2_q;
      ay3_q     <= ay2_q;
      az3_q     <= az2_q;
      sb3_q.f   <= f2_q;
      sb3_q.sat <= sat2_q;
      sb3_q.dx  <= dx2_q;
      sb3_q.dz  <= dz2_q;
      sb3_q.ry  <= RED_W'(dy2_q >>> k2_q);

      sqx4_q <= rx3_q * rx3_q;
      sqz4_q <= rz3_q * rz3_q;
      pdx4_q <= ax3_q * ax3_q;
      pdy4_q <= ay3_q * ay3_q;
      pdz4_q <= az3_q * az3_q;

      ne5_q <= (64'(sqx4_q) + 64'(sqz4_q)) << ELEV_SQ_SHIFT;
      nd5_q <= 64'(pdx4_q) + 64'(pdy4_q) + 64'(pdz4_q);

      sbd_q[0] <= sb3_q;
      for (int j = 1; j < SQW + 2; j++) begin
        sbd_q[j] <= sbd_q[j-1];
      end

      sb2_q[0].f   <= sbs.f;
      sb2_q[0].sat <= sbs.sat;
      sb2_q[0].dr  <= dr_d;
      for (int j = 1; j < CL; j++) begin
        sb2_q[j] <= sb2_q[j-1];
      end

      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], in_vld_i};
    end
  end

  pphed_isqrt #(.W(SQW)) u_sqrt_elev (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (ne5_q),
    .root_o (root_e),
    .rem_o  ()
  );

  pphed_isqrt #(.W(SQW)) u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (nd5_q),
    .root_o (root_d),
    .rem_o  (rem_d)
  );

  pphed_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic_head (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (hx),
    .y_i   (hy),
    .z_o   (zh)
  );

  pphed_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic_elev (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (ex),
    .y_i   (ey),
    .z_o   (ze)
  );

  always_comb begin
    if (sbc.f.dz_zero) begin
      res_d.heading = sbc.f.dx_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else begin
      res_d.heading = to_q13(zh, PI_Q13);
    end
    res_d.elevation = sbc.f.all_zero ? '0 : 15'(to_q13(-ze, HALF_PI_Q13));
    if (sbc.sat || (sbc.dr > (SQW+1)'(DIST_MAX))) begin
      res_d.distance = DIST_MAX;
    end else begin
      res_d.distance = 25'(sbc.dr);
    end
  end

  assign out_vld_o = vld_q[LAT-1];
  assign res_o     = res_q;

endmodule

`default_nettype wire

/* hw/rtl/point_pair_heading_elevation_distance_top.sv */
// Throughput: one point pair per cycle while the result queue has room; the back end is a single
//   stall-together pipeline of two 32-stage square roots and two CORDIC vectoring units.
// Reset: rst_ni clears queue pointers, counts and valid bits only; no clearing pass, ready at once.
// Depends on pphed_pkg, pphed_fifo, pphed_back and the assertion macro header.
`default_nettype none
`include "point_pair_heading_elevation_distance_top_defines.svh"

module point_pair_heading_elevation_distance_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] source_x_i,
  input  logic signed [COORD_BITS-1:0] source_y_i,
  input  logic signed [COORD_BITS-1:0] source_z_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  input  logic signed [COORD_BITS-1:0] target_z_i,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic signed [15:0]           heading_o,
  output logic signed [14:0]           elevation_o,
  output logic [24:0]                  distance_o
);
  import pphed_pkg::*;

  localparam int DW       = COORD_BITS + 1;
  localparam int FW       = $bits(flags_t);
  localparam int MW       = FW + 3 * DW;
  localparam int RW       = $bits(res_t);
  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  // ---------------------------------------------------------------------------
  // Front end: form the deltas and classify the axis cases. Everything here is
  // one subtract and a few zero tests, so it writes straight into the queue.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dx, dy, dz;
  flags_t               fl;

  assign dx = DW'(target_x_i) - DW'(source_x_i);
  assign dy = DW'(target_y_i) - DW'(source_y_i);
  assign dz = DW'(target_z_i) - DW'(source_z_i);

  // heading with zero dz is +-pi/2 by sign of dx; all-zero length gives 0 elevation
  assign fl.dz_zero  = (dz == '0);
  assign fl.dx_pos   = !dx[DW-1] && (dx != '0);
  assign fl.all_zero = (dx == '0) && (dy == '0) && (dz == '0);

  // ---------------------------------------------------------------------------
  // Decoupling queue between front and back
  // ---------------------------------------------------------------------------
  logic [MW-1:0] mq_rdata;
  logic          mq_empty, mq_pop;

  pphed_fifo #(.DEPTH(MQ_DEPTH), .W(MW)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({fl, dx, dy, dz}),
    .full_o  (full),
    .pop_i   (mq_pop),
    .data_o  (mq_rdata),
    .empty_o (mq_empty)
  );

  // ---------------------------------------------------------------------------
  // Back end. The whole pipeline advances together; it only holds when its last
  // stage carries a result and the result queue has no room.
  // ---------------------------------------------------------------------------
  logic          bk_en, bk_vld;
  logic          oq_full;
  res_t          bk_res;
  logic [RW-1:0] oq_rdata;
  res_t          oq_res;

  assign bk_en  = !(bk_vld && oq_full);
  assign mq_pop = bk_en && !mq_empty;

  pphed_back #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (bk_en),
    .in_vld_i  (!mq_empty),
    .dx_i      ($signed(mq_rdata[3*DW-1 -: DW])),
    .dy_i      ($signed(mq_rdata[2*DW-1 -: DW])),
    .dz_i      ($signed(mq_rdata[DW-1:0])),
    .flags_i   (flags_t'(mq_rdata[MW-1 -: FW])),
    .out_vld_o (bk_vld),
    .res_o     (bk_res)
  );

  // Result queue: lets a new beat enter while a finished one waits to be popped.
  pphed_fifo #(.DEPTH(OQ_DEPTH), .W(RW)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_vld),
    .data_i  (bk_res),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (oq_rdata),
    .empty_o (empty)
  );

  assign oq_res      = res_t'(oq_rdata);
  assign heading_o   = oq_res.heading;
  assign elevation_o = oq_res.elevation;
  assign distance_o  = oq_res.distance;

  `PPHED_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, bk_vld && oq_full, bk_vld, "result dropped during stall")
  `PPHED_ASSERT(a_head_range, clk_i, rst_ni, !empty, (heading_o <= PI_Q13) && (heading_o >= -PI_Q13), "heading out of range")
  `PPHED_ASSERT(a_elev_range, clk_i, rst_ni, !empty, (elevation_o <= HALF_PI_Q13) && (elevation_o >= -HALF_PI_Q13), "elevation out of range")

endmodule

`default_nettype wire
